@@ rtl/phase_vocoder_freq_estimator_unit_assert.svh @@
// ---------------------------------------------------------------------------
// Phase vocoder frequency estimator assertion macros
// Shared property forms used by the estimator RTL.
// ---------------------------------------------------------------------------
`ifndef PHASE_VOCODER_FREQ_ESTIMATOR_UNIT_ASSERT_SVH
`define PHASE_VOCODER_FREQ_ESTIMATOR_UNIT_ASSERT_SVH

`define PVFE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define PVFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pvfe_pkg.sv @@
// ---------------------------------------------------------------------------
// Phase vocoder frequency estimator package
// Widths, register codes, defaults and the arctangent table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pvfe_pkg;

    localparam int MAX_FFT_LOG2_DEF = 16;
    localparam int ATAN_STEPS_DEF   = 16;

    localparam int BIN_W      = 16;
    localparam int SMP_W      = 32;
    localparam int FFT_W      = 17;
    localparam int HOP_W      = 17;
    localparam int SR_W       = 18;
    localparam int FREQ_W     = 27;
    localparam int PH_W       = 16;
    localparam int ANG_W      = 32;
    localparam int CORDIC_W   = 35;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;
    localparam int Q_OFS      = 26;

    localparam int FREQ_LIMIT = 50000000;
    localparam int FFT_RST    = 1024;
    localparam int HOP_RST    = 256;
    localparam int SR_RST     = 44100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FFT_SIZE    = 2'd0,
        CFG_HOP_SIZE    = 2'd1,
        CFG_SAMPLE_RATE = 2'd2
    } t_cfg_idx;

    function automatic logic [ANG_W-1:0] atan_val(input int idx);
        logic [ANG_W-1:0] v;
        case (idx)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051E;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2F;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2F9;
            15:      v = 32'h0000517D;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A30;
            19:      v = 32'h00000518;
            20:      v = 32'h0000028C;
            21:      v = 32'h00000146;
            22:      v = 32'h000000A3;
            23:      v = 32'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/pvfe_in_if.sv @@
// ---------------------------------------------------------------------------
// Bin input channel
// Carries one spectral bin item per handshake.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pvfe_in_if;
    import pvfe_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [BIN_W-1:0]        bin_index;
    logic signed [SMP_W-1:0] old_real;
    logic signed [SMP_W-1:0] old_imag;
    logic signed [SMP_W-1:0] new_real;
    logic signed [SMP_W-1:0] new_imag;
    logic                    next_exists;

    modport source (output valid, bin_index, old_real, old_imag, new_real, new_imag,
                    next_exists, input ready);
    modport sink (input valid, bin_index, old_real, old_imag, new_real, new_imag,
                  next_exists, output ready);
endinterface

`default_nettype wire

@@ rtl/pvfe_out_if.sv @@
// ---------------------------------------------------------------------------
// Frequency result channel
// Carries one frequency estimate item per handshake.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pvfe_out_if;
    import pvfe_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [FREQ_W-1:0] freq_hz_q8;
    logic                     valid_res;

    modport source (output valid, freq_hz_q8, valid_res, input ready);
    modport sink (input valid, freq_hz_q8, valid_res, output ready);
endinterface

`default_nettype wire

@@ rtl/pvfe_div.sv @@
// ---------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage; keeps the low quotient bits and flags the rest.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pvfe_div #(
    parameter int NUM_W = 50,
    parameter int DEN_W = 17,
    parameter int Q_W   = 16,
    parameter int SB_W  = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [SB_W-1:0]  i_sb,
    output logic             o_valid,
    output logic [Q_W-1:0]   o_q,
    output logic             o_hi,
    output logic [SB_W-1:0]  o_sb
);
    logic             r_v   [NUM_W];
    logic [NUM_W-1:0] r_num [NUM_W];
    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [Q_W-1:0]   r_q   [NUM_W];
    logic             r_hi  [NUM_W];
    logic [SB_W-1:0]  r_sb  [NUM_W];

    logic             n_v   [NUM_W];
    logic [NUM_W-1:0] n_num [NUM_W];
    logic [DEN_W-1:0] n_rem [NUM_W];
    logic [Q_W-1:0]   n_q   [NUM_W];
    logic             n_hi  [NUM_W];
    logic [SB_W-1:0]  n_sb  [NUM_W];

    always_comb begin
        logic [NUM_W-1:0] p_num;
        logic [DEN_W-1:0] p_rem;
        logic [Q_W-1:0]   p_q;
        logic             p_hi;
        logic [DEN_W:0]   rs;
        logic             ge;
        for (int k = 0; k < NUM_W; k++) begin
            if (k == 0) begin
                p_num   = i_num;
                p_rem   = '0;
                p_q     = '0;
                p_hi    = 1'b0;
                n_v[k]  = i_valid;
                n_sb[k] = i_sb;
            end else begin
                p_num   = r_num[k-1];
                p_rem   = r_rem[k-1];
                p_q     = r_q[k-1];
                p_hi    = r_hi[k-1];
                n_v[k]  = r_v[k-1];
                n_sb[k] = r_sb[k-1];
            end
            rs       = {p_rem, p_num[NUM_W-1]};
            ge       = (rs >= {1'b0, i_den});
            n_rem[k] = ge ? DEN_W'(rs - {1'b0, i_den}) : DEN_W'(rs);
            n_num[k] = p_num << 1;
            n_q[k]   = {p_q[Q_W-2:0], ge};
            n_hi[k]  = p_hi | p_q[Q_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_W; k++) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= n_v[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NUM_W; k++) begin
                r_num[k] <= n_num[k];
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
                r_hi[k]  <= n_hi[k];
                r_sb[k]  <= n_sb[k];
            end
        end
    end

    assign o_valid = r_v[NUM_W-1];
    assign o_q     = r_q[NUM_W-1];
    assign o_hi    = r_hi[NUM_W-1];
    assign o_sb    = r_sb[NUM_W-1];
endmodule

`default_nettype wire

@@ rtl/pvfe_cordic.sv @@
// ---------------------------------------------------------------------------
// Pipelined CORDIC phase unit
// Two lanes find the phase of two complex values, one rotation per stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pvfe_cordic #(
    parameter int STEPS = 16,
    parameter int SB_W  = 1
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_en,
    input  logic                                    i_valid,
    input  logic [1:0][pvfe_pkg::SMP_W-1:0]         i_re,
    input  logic [1:0][pvfe_pkg::SMP_W-1:0]         i_im,
    input  logic [SB_W-1:0]                         i_sb,
    output logic                                    o_valid,
    output logic [1:0][pvfe_pkg::PH_W-1:0]          o_ph,
    output logic [SB_W-1:0]                         o_sb
);
    import pvfe_pkg::*;

    localparam int NS = STEPS + 1;
    localparam logic [ANG_W-1:0] ANG_HALF  = ANG_W'(1) << (ANG_W - 1);
    localparam logic [ANG_W-1:0] ANG_ROUND = ANG_W'(1) << (ANG_W - PH_W - 1);

    logic                       r_v   [NS];
    logic [SB_W-1:0]            r_sb  [NS];
    logic signed [CORDIC_W-1:0] r_x   [2][NS];
    logic signed [CORDIC_W-1:0] r_y   [2][NS];
    logic [ANG_W-1:0]           r_ang [2][NS];
    logic                       r_z   [2][NS];

    logic                       n_v   [NS];
    logic [SB_W-1:0]            n_sb  [NS];
    logic signed [CORDIC_W-1:0] n_x   [2][NS];
    logic signed [CORDIC_W-1:0] n_y   [2][NS];
    logic [ANG_W-1:0]           n_ang [2][NS];
    logic                       n_z   [2][NS];

    always_comb begin
        logic signed [CORDIC_W-1:0] re;
        logic signed [CORDIC_W-1:0] im;
        logic signed [CORDIC_W-1:0] dx;
        logic signed [CORDIC_W-1:0] dy;
        n_v[0]  = i_valid;
        n_sb[0] = i_sb;
        for (int l = 0; l < 2; l++) begin
            re          = CORDIC_W'($signed(i_re[l]));
            im          = CORDIC_W'($signed(i_im[l]));
            n_z[l][0]   = (re == '0) && (im == '0);
            n_x[l][0]   = re[CORDIC_W-1] ? -re : re;
            n_y[l][0]   = re[CORDIC_W-1] ? -im : im;
            n_ang[l][0] = re[CORDIC_W-1] ? ANG_HALF : '0;
        end
        for (int k = 1; k < NS; k++) begin
            n_v[k]  = r_v[k-1];
            n_sb[k] = r_sb[k-1];
            for (int l = 0; l < 2; l++) begin
                dx        = r_y[l][k-1] >>> (k - 1);
                dy        = r_x[l][k-1] >>> (k - 1);
                n_z[l][k] = r_z[l][k-1];
                if (r_y[l][k-1] > 0) begin
                    n_x[l][k]   = r_x[l][k-1] + dx;
                    n_y[l][k]   = r_y[l][k-1] - dy;
                    n_ang[l][k] = r_ang[l][k-1] + atan_val(k - 1);
                end else begin
                    n_x[l][k]   = r_x[l][k-1] - dx;
                    n_y[l][k]   = r_y[l][k-1] + dy;
                    n_ang[l][k] = r_ang[l][k-1] - atan_val(k - 1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= n_v[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NS; k++) begin
                r_sb[k] <= n_sb[k];
                for (int l = 0; l < 2; l++) begin
                    r_x[l][k]   <= n_x[l][k];
                    r_y[l][k]   <= n_y[l][k];
                    r_ang[l][k] <= n_ang[l][k];
                    r_z[l][k]   <= n_z[l][k];
                end
            end
        end
    end

    always_comb begin
        logic [ANG_W-1:0] rounded;
        for (int l = 0; l < 2; l++) begin
            rounded = r_ang[l][NS-1] + ANG_ROUND;
            o_ph[l] = r_z[l][NS-1] ? '0 : rounded[ANG_W-1 -: PH_W];
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_sb    = r_sb[NS-1];
endmodule

`default_nettype wire

@@ rtl/phase_vocoder_freq_estimator_unit.sv @@
// ---------------------------------------------------------------------------
// Phase vocoder instantaneous frequency estimator
// Refines the frequency of one spectral bin from its phase advance.
// ---------------------------------------------------------------------------
// The block takes one bin item per clock while the output is not stalled and
// gives one result item per item, in order. The pipeline holds a 50-stage
// divider for the expected phase advance, the CORDIC stages and a divider with
// one stage per bit of the wide frequency numerator. A stall at the output
// halts the whole pipeline; nothing is dropped or repeated. Configuration is
// to be written by the user through the plain write port only while no item
// is in flight; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module phase_vocoder_freq_estimator_unit #(
    parameter int MAX_FFT_LOG2 = pvfe_pkg::MAX_FFT_LOG2_DEF,
    parameter int ATAN_STEPS   = pvfe_pkg::ATAN_STEPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pvfe_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pvfe_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pvfe_in_if.sink                         i_bin_ch,
    pvfe_out_if.source                      o_res_ch
);
    import pvfe_pkg::*;

    `include "phase_vocoder_freq_estimator_unit_assert.svh"

    localparam int N_W      = MAX_FFT_LOG2 + 1;
    localparam int D_W      = N_W + HOP_W;
    localparam int EX_NUM_W = BIN_W + HOP_W + PH_W + 1;
    localparam int A1_W     = SR_W + BIN_W;
    localparam int T1_W     = A1_W + HOP_W;
    localparam int T2_W     = SR_W + PH_W + 1;
    localparam int T3_W     = T2_W + N_W + 1;
    localparam int MN_W     = (D_W + Q_OFS + 9 > T1_W + 17) ? D_W + Q_OFS + 9 : T1_W + 17;
    localparam int MD_W     = D_W + 8;
    localparam int RAW_W    = 4 * SMP_W;
    localparam int EX_SB_W  = RAW_W + 1 + A1_W;
    localparam int CD_SB_W  = PH_W + 1 + A1_W;
    localparam int N_RST    = (FFT_RST > (1 << MAX_FFT_LOG2)) ? (1 << MAX_FFT_LOG2) : FFT_RST;

    localparam logic [N_W-1:0]           N_MAX  = N_W'(1) << MAX_FFT_LOG2;
    localparam logic [FREQ_W-1:0]        Q_BIAS = FREQ_W'(1) << Q_OFS;
    localparam logic [FREQ_W-1:0]        Q_SAT  = FREQ_W'(FREQ_LIMIT) + Q_BIAS;
    localparam logic [FREQ_W-1:0]        Q_LOW  = Q_BIAS - FREQ_W'(FREQ_LIMIT);
    localparam logic signed [FREQ_W-1:0] F_MAX  = FREQ_W'(FREQ_LIMIT);

    logic [N_W-1:0]   r_n;
    logic [HOP_W-1:0] r_h;
    logic [SR_W-1:0]  r_sr;
    logic [D_W-1:0]   r_d;
    logic [FFT_W-1:0] cfg_fft;
    logic [HOP_W-1:0] cfg_hop;
    logic [N_W-1:0]   n_n;

    assign cfg_fft = i_cfg_data[FFT_W-1:0];
    assign cfg_hop = i_cfg_data[HOP_W-1:0];

    always_comb begin
        if (cfg_fft == '0) begin
            n_n = N_W'(1);
        end else if (cfg_fft > FFT_W'(N_MAX)) begin
            n_n = N_MAX;
        end else begin
            n_n = N_W'(cfg_fft);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n  <= N_W'(N_RST);
            r_h  <= HOP_W'(HOP_RST);
            r_sr <= SR_W'(SR_RST);
            r_d  <= D_W'(N_RST * HOP_RST);
        end else begin
            r_d <= D_W'(r_n) * D_W'(r_h);
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FFT_SIZE: begin
                        r_n <= n_n;
                    end
                    CFG_HOP_SIZE: begin
                        r_h <= (cfg_hop == '0) ? HOP_W'(1) : cfg_hop;
                    end
                    CFG_SAMPLE_RATE: begin
                        r_sr <= i_cfg_data[SR_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    logic en;
    assign en             = !o_res_ch.valid || o_res_ch.ready;
    assign i_bin_ch.ready = en;

    logic                r_v1;
    logic [EX_NUM_W-1:0] r1_m;
    logic [A1_W-1:0]     r1_a1;
    logic [RAW_W-1:0]    r1_raw;
    logic                r1_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_bin_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_m    <= ((EX_NUM_W'(i_bin_ch.bin_index) * EX_NUM_W'(r_h)) << PH_W)
                       + EX_NUM_W'(r_n >> 1);
            r1_a1   <= A1_W'(i_bin_ch.bin_index) * A1_W'(r_sr);
            r1_raw  <= {i_bin_ch.old_real, i_bin_ch.old_imag,
                        i_bin_ch.new_real, i_bin_ch.new_imag};
            r1_next <= i_bin_ch.next_exists;
        end
    end

    logic               ex_v;
    logic [PH_W-1:0]    ex_q;
    logic [EX_SB_W-1:0] ex_sb;

    pvfe_div #(
        .NUM_W (EX_NUM_W),
        .DEN_W (N_W),
        .Q_W   (PH_W),
        .SB_W  (EX_SB_W)
    ) u_ex_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v1),
        .i_num   (r1_m),
        .i_den   (r_n),
        .i_sb    ({r1_raw, r1_next, r1_a1}),
        .o_valid (ex_v),
        .o_q     (ex_q),
        .o_hi    (),
        .o_sb    (ex_sb)
    );

    logic [RAW_W-1:0]          ex_raw;
    logic [1:0][SMP_W-1:0]     cd_re;
    logic [1:0][SMP_W-1:0]     cd_im;
    logic                      cd_v;
    logic [1:0][PH_W-1:0]      cd_ph;
    logic [CD_SB_W-1:0]        cd_sb;

    assign ex_raw   = ex_sb[EX_SB_W-1 -: RAW_W];
    assign cd_re[0] = ex_raw[4*SMP_W-1 -: SMP_W];
    assign cd_im[0] = ex_raw[3*SMP_W-1 -: SMP_W];
    assign cd_re[1] = ex_raw[2*SMP_W-1 -: SMP_W];
    assign cd_im[1] = ex_raw[SMP_W-1:0];

    pvfe_cordic #(
        .STEPS (ATAN_STEPS),
        .SB_W  (CD_SB_W)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (ex_v),
        .i_re    (cd_re),
        .i_im    (cd_im),
        .i_sb    ({ex_q, ex_sb[A1_W:0]}),
        .o_valid (cd_v),
        .o_ph    (cd_ph),
        .o_sb    (cd_sb)
    );

    logic                   r_v2;
    logic signed [PH_W-1:0] r2_err;
    logic                   r2_next;
    logic [A1_W-1:0]        r2_a1;

    logic                   r_v3;
    logic [T1_W-1:0]        r3_t1;
    logic signed [T2_W-1:0] r3_t2;
    logic                   r3_next;

    logic                   r_v4;
    logic [T1_W-1:0]        r4_t1;
    logic signed [T3_W-1:0] r4_t3;
    logic                   r4_next;

    logic                   r_v5;
    logic [MN_W-1:0]        r5_num;
    logic                   r5_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v2 <= cd_v;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_err  <= $signed(cd_ph[1] - cd_ph[0] - cd_sb[CD_SB_W-1 -: PH_W]);
            r2_next <= cd_sb[A1_W];
            r2_a1   <= cd_sb[A1_W-1:0];

            r3_t1   <= T1_W'(r2_a1) * T1_W'(r_h);
            r3_t2   <= T2_W'($signed({1'b0, r_sr})) * T2_W'(r2_err);
            r3_next <= r2_next;

            r4_t1   <= r3_t1;
            r4_t3   <= T3_W'(r3_t2) * T3_W'($signed({1'b0, r_n}));
            r4_next <= r3_next;

            r5_num  <= (MN_W'(r4_t1) << 16)
                       + (r4_next ? MN_W'(r4_t3) : '0)
                       + (MN_W'(r_d) << 7)
                       + (MN_W'(r_d) << (Q_OFS + 8));
            r5_next <= r4_next;
        end
    end

    logic              md_v;
    logic [FREQ_W-1:0] md_q;
    logic              md_hi;
    logic              md_next;

    pvfe_div #(
        .NUM_W (MN_W),
        .DEN_W (MD_W),
        .Q_W   (FREQ_W),
        .SB_W  (1)
    ) u_freq_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v5),
        .i_num   (r5_num),
        .i_den   ({r_d, 8'd0}),
        .i_sb    (r5_next),
        .o_valid (md_v),
        .o_q     (md_q),
        .o_hi    (md_hi),
        .o_sb    (md_next)
    );

    logic                     r_out_v;
    logic signed [FREQ_W-1:0] r_out_f;
    logic                     r_out_res;
    logic signed [FREQ_W-1:0] n_out_f;

    always_comb begin
        if (md_hi || (md_q > Q_SAT)) begin
            n_out_f = F_MAX;
        end else if (md_q < Q_LOW) begin
            n_out_f = -F_MAX;
        end else begin
            n_out_f = $signed(md_q - Q_BIAS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= md_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_f   <= n_out_f;
            r_out_res <= md_next;
        end
    end

    assign o_res_ch.valid      = r_out_v;
    assign o_res_ch.freq_hz_q8 = r_out_f;
    assign o_res_ch.valid_res  = r_out_res;

    `PVFE_ASSERT_IMPLY(a_freq_range, i_clk, i_rst_n, r_out_v,
        (r_out_f <= F_MAX) && (r_out_f >= -F_MAX), "Frequency result out of range.")
    `PVFE_ASSERT_IMPLY(a_stall_blocks_input, i_clk, i_rst_n, r_out_v && !o_res_ch.ready,
        !i_bin_ch.ready, "Input taken while the result register is stalled.")
    `PVFE_ASSERT_NEXT(a_zero_rate, i_clk, i_rst_n, en && md_v && (r_sr == '0),
        r_out_f == '0, "Zero sample rate gave a non-zero frequency.")
endmodule

`default_nettype wire
